// File: sv/parity_steered_weighted_two_queue_server_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-queue server
// Shared property forms used by the concurrent checks of the top level.
// ---------------------------------------------------------------------------
`ifndef PARITY_STEERED_WEIGHTED_TWO_QUEUE_SERVER_DEFINES_SVH
`define PARITY_STEERED_WEIGHTED_TWO_QUEUE_SERVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSWQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pswq_pkg.sv
// ---------------------------------------------------------------------------
// pswq_pkg
// Types, constants and helpers shared by the two-queue server modules.
// ---------------------------------------------------------------------------
package pswq_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int ID_WIDTH    = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int WEIGHT_W    = 4;
    localparam int CFG_IDX_W   = 2;

    // Both small queues must have a power-of-two depth; their pointers wrap naturally.
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_A_RESET = WEIGHT_W'(2);
    localparam logic [WEIGHT_W-1:0] WEIGHT_B_RESET = WEIGHT_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_B = CFG_IDX_W'(1);

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_SERVE   = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_SERVED   = 2'd0,
        ST_NOTHING  = 2'd1,
        ST_ENQUEUED = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

    typedef struct packed {
        t_command              command;
        logic [ID_WIDTH-1:0]   customer_id;
    } t_item;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   served_id;
        logic                  window;
        t_status               status;
        logic                  batch_done;
    } t_result;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        t_command              command;
        logic [ID_WIDTH-1:0]   customer_id;
        logic                  to_b;
    } t_cmd;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [WEIGHT_W-1:0]   data;
    } t_cfg_wr;

    typedef struct packed {
        logic                  reading;
        logic                  res_push;
    } t_back_stat;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

// File: sv/pswq_front.sv
// ---------------------------------------------------------------------------
// pswq_front
// Accepts requests, tags each by id parity and holds them in a short queue.
// ---------------------------------------------------------------------------
module pswq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  pswq_pkg::t_item  i_item,
    output logic             o_cmd_valid,
    output pswq_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_pop
);
    import pswq_pkg::*;

    t_cmd                  r_slot [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  w_push;
    logic                  w_pop;
    t_cmd                  w_tagged;

    assign full        = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    // Odd ids belong to queue A, even ids to queue B.
    always_comb begin
        w_tagged.command     = i_item.command;
        w_tagged.customer_id = i_item.customer_id;
        w_tagged.to_b        = ~i_item.customer_id[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_tagged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_PTR_W'(1);
            end
            r_count <= r_count + CMDQ_CNT_W'(w_push) - CMDQ_CNT_W'(w_pop);
        end
    end

endmodule

// File: sv/pswq_back.sv
// ---------------------------------------------------------------------------
// pswq_back
// Runs classified requests against the two id stores, keeps the weighted
// turn and buffers the results.
// ---------------------------------------------------------------------------
module pswq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pswq_pkg::t_cfg_wr    i_cfg,
    input  logic                 i_cmd_valid,
    input  pswq_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    output pswq_pkg::t_result    o_result,
    output logic                 empty,
    input  logic                 pop,
    output pswq_pkg::t_back_stat o_stat
);
    import pswq_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_READ = 2'b10
    } t_back_state;

    logic [ID_WIDTH-1:0]   mem_a [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   mem_b [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   r_rdata_a;
    logic [ID_WIDTH-1:0]   r_rdata_b;

    t_back_state           r_state,    n_state;
    logic [WEIGHT_W-1:0]   r_weight_a;
    logic [WEIGHT_W-1:0]   r_weight_b;
    logic [PTR_W-1:0]      r_head_a,   n_head_a;
    logic [PTR_W-1:0]      r_tail_a,   n_tail_a;
    logic [FILL_W-1:0]     r_fill_a,   n_fill_a;
    logic [PTR_W-1:0]      r_head_b,   n_head_b;
    logic [PTR_W-1:0]      r_tail_b,   n_tail_b;
    logic [FILL_W-1:0]     r_fill_b,   n_fill_b;
    logic                  r_turn_b,   n_turn_b;
    logic [WEIGHT_W-1:0]   r_turn_cnt, n_turn_cnt;
    logic                  r_pend_win, n_pend_win;
    logic                  r_pend_done, n_pend_done;

    t_result               r_res [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] r_res_wr;
    logic [RESQ_PTR_W-1:0] r_res_rd;
    logic [RESQ_CNT_W-1:0] r_res_cnt;

    logic                  w_go;
    logic                  w_serve;
    logic                  w_any;
    logic                  w_eff_b;
    logic [WEIGHT_W-1:0]   w_cnt;
    logic [WEIGHT_W-1:0]   w_cnt1;
    logic [WEIGHT_W-1:0]   w_weight;
    logic                  w_a_full;
    logic                  w_b_full;
    logic                  w_wr_a;
    logic                  w_wr_b;
    logic                  w_rd_a;
    logic                  w_rd_b;
    logic                  w_res_push;
    logic                  w_res_pop;
    t_result               w_res;

    assign w_go    = (r_state == BK_IDLE) && i_cmd_valid
                     && (r_res_cnt != RESQ_CNT_W'(RESQ_DEPTH));
    assign w_serve = (i_cmd.command == CMD_SERVE);
    assign w_any   = (r_fill_a != '0) || (r_fill_b != '0);
    assign w_a_full = (r_fill_a == FILL_W'(QUEUE_DEPTH));
    assign w_b_full = (r_fill_b == FILL_W'(QUEUE_DEPTH));

    assign o_cmd_pop = w_go;

    // An empty queue that holds the turn passes it over with a fresh count.
    always_comb begin
        w_eff_b = r_turn_b;
        w_cnt   = r_turn_cnt;
        if (!r_turn_b && (r_fill_a == '0)) begin
            w_eff_b = 1'b1;
            w_cnt   = '0;
        end else if (r_turn_b && (r_fill_b == '0)) begin
            w_eff_b = 1'b0;
            w_cnt   = '0;
        end
        w_cnt1   = w_cnt + WEIGHT_W'(1);
        w_weight = w_eff_b ? r_weight_b : r_weight_a;
    end

    assign w_wr_a = w_go && !w_serve && !i_cmd.to_b && !w_a_full;
    assign w_wr_b = w_go && !w_serve &&  i_cmd.to_b && !w_b_full;
    assign w_rd_a = w_go &&  w_serve && w_any && !w_eff_b;
    assign w_rd_b = w_go &&  w_serve && w_any &&  w_eff_b;

    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            mem_a[r_tail_a] <= i_cmd.customer_id;
        end
        if (w_rd_a) begin
            r_rdata_a <= mem_a[r_head_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_b) begin
            mem_b[r_tail_b] <= i_cmd.customer_id;
        end
        if (w_rd_b) begin
            r_rdata_b <= mem_b[r_head_b];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head_a    = r_head_a;
        n_tail_a    = r_tail_a;
        n_fill_a    = r_fill_a;
        n_head_b    = r_head_b;
        n_tail_b    = r_tail_b;
        n_fill_b    = r_fill_b;
        n_turn_b    = r_turn_b;
        n_turn_cnt  = r_turn_cnt;
        n_pend_win  = r_pend_win;
        n_pend_done = r_pend_done;
        unique case (r_state)
            BK_IDLE: begin
                if (w_wr_a) begin
                    n_tail_a = ptr_next(r_tail_a);
                    n_fill_a = r_fill_a + FILL_W'(1);
                end
                if (w_wr_b) begin
                    n_tail_b = ptr_next(r_tail_b);
                    n_fill_b = r_fill_b + FILL_W'(1);
                end
                if (w_rd_a) begin
                    n_head_a = ptr_next(r_head_a);
                    n_fill_a = r_fill_a - FILL_W'(1);
                end
                if (w_rd_b) begin
                    n_head_b = ptr_next(r_head_b);
                    n_fill_b = r_fill_b - FILL_W'(1);
                end
                if (w_rd_a || w_rd_b) begin
                    if (w_cnt1 >= w_weight) begin
                        n_turn_b   = ~w_eff_b;
                        n_turn_cnt = '0;
                    end else begin
                        n_turn_b   = w_eff_b;
                        n_turn_cnt = w_cnt1;
                    end
                    n_pend_done = 1'b0;
                    if ((n_fill_a == '0) && (n_fill_b == '0)) begin
                        n_turn_b    = 1'b0;
                        n_turn_cnt  = '0;
                        n_pend_done = 1'b1;
                    end
                    n_pend_win = w_eff_b;
                    n_state    = BK_READ;
                end
            end
            BK_READ: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Result of the current cycle: a finished pop, or an immediate answer.
    always_comb begin
        w_res.served_id  = '0;
        w_res.window     = 1'b0;
        w_res.status     = ST_NOTHING;
        w_res.batch_done = 1'b0;
        w_res_push       = 1'b0;
        if (r_state == BK_READ) begin
            w_res.served_id  = r_pend_win ? r_rdata_b : r_rdata_a;
            w_res.window     = r_pend_win;
            w_res.status     = ST_SERVED;
            w_res.batch_done = r_pend_done;
            w_res_push       = 1'b1;
        end else if (w_go && !w_serve) begin
            w_res.window = i_cmd.to_b;
            if (i_cmd.to_b ? w_b_full : w_a_full) begin
                w_res.status = ST_DROPPED;
            end else begin
                w_res.status = ST_ENQUEUED;
            end
            w_res_push = 1'b1;
        end else if (w_go && !w_any) begin
            w_res_push = 1'b1;
        end
    end

    assign w_res_pop = pop && !empty;
    assign empty     = (r_res_cnt == '0);
    assign o_result  = r_res[r_res_rd];

    assign o_stat.reading  = (r_state == BK_READ);
    assign o_stat.res_push = w_res_push;

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_res[r_res_wr] <= w_res;
        end
        r_pend_win  <= n_pend_win;
        r_pend_done <= n_pend_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_weight_a <= WEIGHT_A_RESET;
            r_weight_b <= WEIGHT_B_RESET;
            r_head_a   <= '0;
            r_tail_a   <= '0;
            r_fill_a   <= '0;
            r_head_b   <= '0;
            r_tail_b   <= '0;
            r_fill_b   <= '0;
            r_turn_b   <= 1'b0;
            r_turn_cnt <= '0;
            r_res_wr   <= '0;
            r_res_rd   <= '0;
            r_res_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_head_a   <= n_head_a;
            r_tail_a   <= n_tail_a;
            r_fill_a   <= n_fill_a;
            r_head_b   <= n_head_b;
            r_tail_b   <= n_tail_b;
            r_fill_b   <= n_fill_b;
            r_turn_b   <= n_turn_b;
            r_turn_cnt <= n_turn_cnt;
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_WEIGHT_A) begin
                    r_weight_a <= i_cfg.data;
                end else if (i_cfg.index == REG_WEIGHT_B) begin
                    r_weight_b <= i_cfg.data;
                end
            end
            if (w_res_push) begin
                r_res_wr <= r_res_wr + RESQ_PTR_W'(1);
            end
            if (w_res_pop) begin
                r_res_rd <= r_res_rd + RESQ_PTR_W'(1);
            end
            r_res_cnt <= r_res_cnt + RESQ_CNT_W'(w_res_push) - RESQ_CNT_W'(w_res_pop);
        end
    end

endmodule

// File: sv/parity_steered_weighted_two_queue_server.sv
// ---------------------------------------------------------------------------
// parity_steered_weighted_two_queue_server
// Two id queues fed by parity, served under weighted round robin.
// ---------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  request   push / full                  i_item   (command, customer_id)
//  result    empty / pop                  o_result (served_id, window, status,
//                                                   batch_done)
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  An enqueue or a serve that finds nothing queued is written to the result buffer
//  in the cycle the back end takes it; a serve that pops is written from the registered
//  read of the id store, in the back end's read state. Reset is synchronous; the stores
//  are never read unwritten. full rises when both request queue entries hold requests;
//  the back end waits while both result buffer entries are held. Configuration is
//  always ready.
// ---------------------------------------------------------------------------
`include "parity_steered_weighted_two_queue_server_defines.svh"

module parity_steered_weighted_two_queue_server (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  pswq_pkg::t_item                   i_item,
    output logic                              empty,
    input  logic                              pop,
    output pswq_pkg::t_result                 o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pswq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pswq_pkg::WEIGHT_W-1:0]     i_cfg_data
);
    import pswq_pkg::*;

    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_cmd_pop;
    t_cfg_wr    w_cfg;
    t_back_stat w_bstat;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg.valid = i_cfg_valid && o_cfg_ready;
        w_cfg.index = i_cfg_index;
        w_cfg.data  = i_cfg_data;
    end

    pswq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    pswq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop),
        .o_stat      (w_bstat)
    );

    `PSWQ_ASSERT_SAME(a_pop_needs_cmd, i_clk, i_rst_n, w_cmd_pop, w_cmd_valid,
        "back end took a request from an empty queue")
    `PSWQ_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && !full && !w_cmd_valid, w_cmd_valid,
        "accepted request did not reach the back end")
    `PSWQ_ASSERT_NEXT(a_read_delivers, i_clk, i_rst_n, w_bstat.reading, !empty,
        "pop read finished without a buffered result")
    `PSWQ_ASSERT_SAME(a_no_take_in_read, i_clk, i_rst_n, w_bstat.reading, !w_cmd_pop,
        "new request taken while a pop read is in flight")
    `PSWQ_ASSERT_SAME(a_read_pushes, i_clk, i_rst_n, w_bstat.reading, w_bstat.res_push,
        "pop read finished without writing its result")

endmodule
